@@ hdl/hierarchical_bitmap_slot_allocator_defines.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef HIERARCHICAL_BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define HIERARCHICAL_BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define HBSA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("hbsa assertion failed");
`define HBSA_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("hbsa assertion failed");
`else
`define HBSA_ASSERT(lbl, clk, rst_n, prop)
`define HBSA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ hdl/hbsa_pkg.sv @@
package hbsa_pkg;
	localparam int unsigned WordW   = 32;
	localparam int unsigned IdxW    = 5;
	localparam int unsigned SlotW   = 20;
	localparam int unsigned CountW  = 21;
	localparam int unsigned L3AddrW = 10;
	localparam int unsigned LfAddrW = 15;
	localparam logic [CountW-1:0] CountMax = 21'h100000;

	typedef logic [WordW-1:0] word_t;
	typedef logic [IdxW-1:0]  idx_t;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_RANGE = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_R_RD,
		ST_R_WB,
		ST_A_L3,
		ST_A_LF,
		ST_DONE
	} state_t;

	// Lowest set bit; an empty word gives the top index.
	function automatic idx_t ffs(input word_t w);
		idx_t r;
		r = idx_t'(WordW - 1);
		for (int i = WordW - 1; i >= 0; i--) begin
			if (w[i]) r = idx_t'(i);
		end
		return r;
	endfunction
endpackage

@@ hdl/hbsa_req_if.sv @@
interface hbsa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [19:0] slot;
	logic [19:0] range_start;
	logic [20:0] range_end;
	modport source (output valid, op, slot, range_start, range_end, input ready);
	modport sink (input valid, op, slot, range_start, range_end, output ready);
endinterface

@@ hdl/hbsa_rsp_if.sv @@
interface hbsa_rsp_if;
	logic        valid;
	logic        ready;
	logic [19:0] granted_slot;
	logic        granted;
	logic [20:0] free_count;
	modport source (output valid, granted_slot, granted, free_count, input ready);
	modport sink (input valid, granted_slot, granted, free_count, output ready);
endinterface

@@ hdl/hbsa_ram.sv @@
module hbsa_ram import hbsa_pkg::*; #(
	parameter int unsigned AW = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  word_t         wdata,
	input  logic [AW-1:0] raddr,
	output word_t         rdata
);
	word_t mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ hdl/hierarchical_bitmap_slot_allocator.sv @@
// Channel | Dir | Fields
// req     | in  | op, slot, range_start, range_end
// rsp     | out | granted_slot, granted, free_count
// Allocate, when a slot is free, makes two dependent reads: the level-three memory, then the leaf memory.
// Free reads and writes back its one slot; a range does a read and write-back for each slot in turn.
// After reset a clearing pass zeroes both memories; req.ready stays low.
// A result waits in an output register, so a stalled rsp only blocks the next result.
`include "hierarchical_bitmap_slot_allocator_defines.svh"
module hierarchical_bitmap_slot_allocator import hbsa_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	hbsa_req_if.sink    req,
	hbsa_rsp_if.source  rsp
);
	state_t state_q, state_d;
	logic [LfAddrW-1:0] clr_q;
	logic [SlotW-1:0] cur_q;
	logic [CountW-1:0] hi_q, cnt_q, res_cnt_q;
	idx_t i1_q, i2_q, i3_q;
	word_t w3_q, top_q;
	word_t l2_q [WordW];
	logic [SlotW-1:0] res_slot_q, slot_q;
	logic res_gnt_q, rsp_vld_q, gnt_q;

	logic accept, load;
	logic [SlotW-1:0] start;
	logic [CountW-1:0] hi_clip, add_n;
	logic [CountW:0] sum;
	idx_t i1c, i2c, i3c, i4c;
	word_t leaf_new, l3_new, l2_new;
	logic lf_we, l3_we;
	logic [LfAddrW-1:0] lf_waddr, lf_raddr;
	logic [L3AddrW-1:0] l3_waddr, l3_raddr;
	word_t lf_wdata, l3_wdata, lf_rdata, l3_rdata;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign load = (state_q == ST_DONE) && (!rsp_vld_q || rsp.ready);
	assign start = (op_t'(req.op) == OP_FREE) ? req.slot : req.range_start;
	assign hi_clip = (req.range_end > CountMax) ? CountMax : req.range_end;
	assign add_n = (op_t'(req.op) == OP_FREE) ? CountW'(1) : hi_clip - CountW'(req.range_start);
	assign sum = {1'b0, cnt_q} + {1'b0, add_n};

	assign i1c = ffs(top_q);
	assign i2c = ffs(l2_q[i1c]);
	assign i3c = ffs(l3_rdata);
	assign i4c = ffs(lf_rdata);
	assign leaf_new = lf_rdata & ~(word_t'(1) << i4c);
	assign l3_new = w3_q & ~(word_t'(1) << i3_q);
	assign l2_new = l2_q[i1_q] & ~(word_t'(1) << i2_q);

	always_comb begin
		if (state_q == ST_A_L3) begin
			lf_raddr = {i1_q, i2_q, i3c};
		end else if (state_q == ST_IDLE) begin
			lf_raddr = start[SlotW-1:IdxW];
		end else begin
			lf_raddr = cur_q[SlotW-1:IdxW];
		end
		if (state_q == ST_IDLE && op_t'(req.op) == OP_ALLOC) begin
			l3_raddr = {i1c, i2c};
		end else if (state_q == ST_IDLE) begin
			l3_raddr = start[SlotW-1:2*IdxW];
		end else begin
			l3_raddr = cur_q[SlotW-1:2*IdxW];
		end
		lf_we = 1'b0;
		l3_we = 1'b0;
		lf_waddr = cur_q[SlotW-1:IdxW];
		l3_waddr = cur_q[SlotW-1:2*IdxW];
		lf_wdata = lf_rdata | (word_t'(1) << cur_q[IdxW-1:0]);
		l3_wdata = l3_rdata | (word_t'(1) << cur_q[2*IdxW-1:IdxW]);
		case (state_q)
			ST_CLR: begin
				lf_we = 1'b1;
				l3_we = 1'b1;
				lf_waddr = clr_q;
				l3_waddr = clr_q[L3AddrW-1:0];
				lf_wdata = '0;
				l3_wdata = '0;
			end
			ST_R_WB: begin
				lf_we = 1'b1;
				l3_we = 1'b1;
			end
			ST_A_LF: begin
				lf_we = 1'b1;
				l3_we = (leaf_new == '0);
				lf_waddr = {i1_q, i2_q, i3_q};
				l3_waddr = {i1_q, i2_q};
				lf_wdata = leaf_new;
				l3_wdata = l3_new;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR:  if (clr_q == '1) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					case (op_t'(req.op))
						OP_ALLOC: state_d = (top_q == '0) ? ST_DONE : ST_A_L3;
						OP_FREE:  state_d = ST_R_WB;
						OP_RANGE: state_d = (hi_clip > CountW'(req.range_start)) ?
							ST_R_WB : ST_DONE;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_R_RD: state_d = ST_R_WB;
			ST_R_WB: state_d = (CountW'(cur_q) + CountW'(1) == hi_q) ? ST_DONE : ST_R_RD;
			ST_A_L3: state_d = ST_A_LF;
			ST_A_LF: state_d = ST_DONE;
			ST_DONE: if (load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			cnt_q <= '0;
			top_q <= '0;
			rsp_vld_q <= 1'b0;
			for (int i = 0; i < WordW; i++) l2_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) clr_q <= clr_q + LfAddrW'(1);
			if (load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			if (accept && (state_d == ST_R_WB)) begin
				cnt_q <= (sum >= {1'b0, CountMax}) ? CountMax : sum[CountW-1:0];
			end
			if (state_q == ST_R_WB) begin
				l2_q[cur_q[SlotW-1:3*IdxW]] <= l2_q[cur_q[SlotW-1:3*IdxW]] |
					(word_t'(1) << cur_q[3*IdxW-1:2*IdxW]);
				top_q <= top_q | (word_t'(1) << cur_q[SlotW-1:3*IdxW]);
			end
			if (state_q == ST_A_LF) begin
				if (cnt_q != '0) cnt_q <= cnt_q - CountW'(1);
				// Summary bits clear upward only while a word has emptied.
				if (leaf_new == '0 && l3_new == '0) begin
					l2_q[i1_q] <= l2_new;
					if (l2_new == '0) top_q <= top_q & ~(word_t'(1) << i1_q);
				end
			end
		end
	end

	// The working grant is kept apart from the output register, which may still
	// hold an earlier result while the next request is being worked on.
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= start;
			hi_q <= (op_t'(req.op) == OP_FREE) ? CountW'(req.slot) + CountW'(1) : hi_clip;
			i1_q <= i1c;
			i2_q <= i2c;
			gnt_q <= 1'b0;
			slot_q <= '0;
		end
		if (state_q == ST_R_WB) cur_q <= cur_q + SlotW'(1);
		if (state_q == ST_A_L3) begin
			w3_q <= l3_rdata;
			i3_q <= i3c;
		end
		if (state_q == ST_A_LF) begin
			gnt_q <= 1'b1;
			slot_q <= {i1_q, i2_q, i3_q, i4c};
		end
		if (load) begin
			res_cnt_q <= cnt_q;
			res_gnt_q <= gnt_q;
			res_slot_q <= slot_q;
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.granted = res_gnt_q && rsp_vld_q;
	assign rsp.granted_slot = rsp_vld_q ? res_slot_q : '0;
	assign rsp.free_count = res_cnt_q;

	hbsa_ram #(.AW(L3AddrW)) u_l3 (
		.clk(clk), .we(l3_we), .waddr(l3_waddr), .wdata(l3_wdata),
		.raddr(l3_raddr), .rdata(l3_rdata)
	);
	hbsa_ram #(.AW(LfAddrW)) u_leaf (
		.clk(clk), .we(lf_we), .waddr(lf_waddr), .wdata(lf_wdata),
		.raddr(lf_raddr), .rdata(lf_rdata)
	);

	`HBSA_ASSERT(a_cnt_max, clk, arst_n, cnt_q <= CountMax)
	`HBSA_ASSERT(a_one_at_a_time, clk, arst_n, accept |=> !req.ready)
	`HBSA_ASSERT(a_leaf_nonempty, clk, arst_n, (state_q == ST_A_LF) |-> (lf_rdata != '0))
	`HBSA_ASSERT(a_l3_nonempty, clk, arst_n, (state_q == ST_A_L3) |-> (l3_rdata != '0))
	`HBSA_ASSERT_ALWAYS(a_no_grant_zero, clk, (rsp.valid && !rsp.granted) |-> (rsp.granted_slot == '0))
endmodule

@@ sim/tb_top.sv @@
module tb_top;
	import hbsa_pkg::*;

	localparam int unsigned SlotTotal = 1 << 20;
	localparam int unsigned IdleLimit = 100000;

	typedef struct packed {
		logic [19:0] slot_no;
		logic        granted;
		logic [20:0] count;
	} alloc_result_t;

	typedef struct packed {
		logic [1:0]    op;
		logic [19:0]   slot;
		logic [19:0]   first;
		logic [20:0]   last;
		logic          known;
		alloc_result_t want;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n;

	hbsa_req_if req();
	hbsa_rsp_if rsp();

	hierarchical_bitmap_slot_allocator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Shadow copy of the free map, one array per level, plus the running count.
	word_t       top_map;
	word_t       mid_map [32];
	word_t       low_map [1024];
	word_t       leaf_map [32768];
	int unsigned free_total;

	alloc_result_t pending_results [$];
	int unsigned   owned_slots [$];
	int unsigned   errors;
	int unsigned   idle_cycles;
	bit            hold_req;
	bit            quiet;

	table_row_t request_table [22] = '{
		'{OP_ALLOC, 20'd0, 20'd0, 21'd0, 1'b1, '{20'd0, 1'b0, 21'd0}},
		'{OP_NONE, 20'hFFFFF, 20'hFFFFF, 21'h1FFFFF, 1'b1, '{20'd0, 1'b0, 21'd0}},
		'{OP_FREE, 20'd0, 20'd0, 21'd0, 1'b1, '{20'd0, 1'b0, 21'd1}},
		'{OP_FREE, 20'hFFFFF, 20'd0, 21'd0, 1'b1, '{20'd0, 1'b0, 21'd2}},
		'{OP_FREE, 20'd0, 20'd0, 21'd0, 1'b1, '{20'd0, 1'b0, 21'd3}},
		'{OP_ALLOC, 20'd0, 20'd0, 21'd0, 1'b1, '{20'd0, 1'b1, 21'd2}},
		'{OP_ALLOC, 20'd0, 20'd0, 21'd0, 1'b1, '{20'hFFFFF, 1'b1, 21'd1}},
		'{OP_ALLOC, 20'd0, 20'd0, 21'd0, 1'b1, '{20'd0, 1'b0, 21'd1}},
		'{OP_RANGE, 20'd0, 20'd100, 21'd100, 1'b1, '{20'd0, 1'b0, 21'd1}},
		'{OP_RANGE, 20'd0, 20'd200, 21'd50, 1'b1, '{20'd0, 1'b0, 21'd1}},
		'{OP_RANGE, 20'd0, 20'd1048570, 21'd1048576, 1'b1, '{20'd0, 1'b0, 21'd7}},
		'{OP_RANGE, 20'd0, 20'd1048572, 21'h1FFFFF, 1'b1, '{20'd0, 1'b0, 21'd11}},
		'{OP_ALLOC, 20'd0, 20'd0, 21'd0, 1'b1, '{20'd1048570, 1'b1, 21'd10}},
		'{OP_RANGE, 20'd0, 20'd30, 21'd70, 1'b0, '0},
		'{OP_FREE, 20'd1023, 20'd0, 21'd0, 1'b0, '0},
		'{OP_FREE, 20'd32767, 20'd0, 21'd0, 1'b0, '0},
		'{OP_FREE, 20'd524288, 20'd0, 21'd0, 1'b0, '0},
		'{OP_ALLOC, 20'd0, 20'd0, 21'd0, 1'b0, '0},
		'{OP_ALLOC, 20'd0, 20'd0, 21'd0, 1'b0, '0},
		'{OP_NONE, 20'd0, 20'd0, 21'd0, 1'b0, '0},
		'{OP_RANGE, 20'd0, 20'd0, 21'd1, 1'b0, '0},
		'{OP_ALLOC, 20'd0, 20'd0, 21'd0, 1'b0, '0}
	};

	function automatic int unsigned lowest_free(word_t w);
		int unsigned r;
		r = 31;
		for (int i = 31; i >= 0; i--) begin
			if (w[i]) r = i;
		end
		return r;
	endfunction

	function automatic void mark_slot_free(logic [19:0] s);
		leaf_map[s[19:5]][s[4:0]] = 1'b1;
		low_map[s[19:10]][s[9:5]] = 1'b1;
		mid_map[s[19:15]][s[14:10]] = 1'b1;
		top_map[s[19:15]] = 1'b1;
	endfunction

	function automatic void add_free(int unsigned n);
		if (n >= SlotTotal || free_total > SlotTotal - n) free_total = SlotTotal;
		else free_total = free_total + n;
	endfunction

	function automatic alloc_result_t apply_request(logic [1:0] op, logic [19:0] slot,
			logic [19:0] first, logic [20:0] last);
		alloc_result_t res;
		int unsigned   i1, i2, i3, s, hi;
		res = '0;
		case (op)
			OP_ALLOC: begin
				if (top_map != '0) begin
					i1 = lowest_free(top_map);
					i2 = i1 * 32 + lowest_free(mid_map[i1]);
					i3 = i2 * 32 + lowest_free(low_map[i2]);
					s = i3 * 32 + lowest_free(leaf_map[i3]);
					res.slot_no = s[19:0];
					res.granted = 1'b1;
					// Summary bits are cleared upwards only while a word empties.
					leaf_map[i3][s % 32] = 1'b0;
					if (leaf_map[i3] == '0) begin
						low_map[i2][i3 % 32] = 1'b0;
						if (low_map[i2] == '0) begin
							mid_map[i1][i2 % 32] = 1'b0;
							if (mid_map[i1] == '0) top_map[i1] = 1'b0;
						end
					end
					if (free_total > 0) free_total = free_total - 1;
				end
			end
			OP_FREE: begin
				mark_slot_free(slot);
				add_free(1);
			end
			OP_RANGE: begin
				hi = (last > SlotTotal) ? SlotTotal : last;
				if (hi > first) begin
					add_free(hi - first);
					for (s = first; s < hi; s++) mark_slot_free(s[19:0]);
				end
			end
			default: ;
		endcase
		res.count = free_total[20:0];
		return res;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	// Called at a rising edge; returns at the edge on which the request is taken.
	task automatic send_request(logic [1:0] op, logic [19:0] slot, logic [19:0] first,
			logic [20:0] last, logic known, alloc_result_t want, int unsigned gap);
		alloc_result_t res;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.op <= op;
		req.slot <= slot;
		req.range_start <= first;
		req.range_end <= last;
		do @(posedge clk); while (!req.ready);
		res = apply_request(op, slot, first, last);
		if (op == OP_ALLOC && res.granted) owned_slots.push_back(res.slot_no);
		pending_results.push_back(known ? want : res);
	endtask

	always @(posedge clk) begin
		alloc_result_t want;
		if (rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected: slot %0d granted %0b count %0d",
					$time, rsp.granted_slot, rsp.granted, rsp.free_count);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (rsp.granted_slot !== want.slot_no) begin
					$display("%0t: granted_slot expected %0d actual %0d",
						$time, want.slot_no, rsp.granted_slot);
					errors++;
				end
				if (rsp.granted !== want.granted) begin
					$display("%0t: granted expected %0b actual %0b",
						$time, want.granted, rsp.granted);
					errors++;
				end
				if (rsp.free_count !== want.count) begin
					$display("%0t: free_count expected %0d actual %0d",
						$time, want.count, rsp.free_count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("%0t: no request or result moved for %0d cycles", $time, IdleLimit);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int unsigned stall_left;
		rsp.ready <= 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				// Long hold-off so that the output register fills and the input stalls.
				hold_req = 1'b0;
				rsp.ready <= 1'b0;
				repeat (400) @(posedge clk);
			end else if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp.ready <= 1'b1;
				if (!quiet && $urandom_range(0, 99) < 15)
					stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
						: $urandom_range(1, 3);
			end
		end
	end

	initial begin
		logic [1:0]  op;
		logic [19:0] slot, first;
		logic [20:0] last;
		int unsigned r, len, pick;
		req.valid <= 1'b0;
		req.op <= OP_NONE;
		req.slot <= '0;
		req.range_start <= '0;
		req.range_end <= '0;
		arst_n = 1'b0;
		top_map = '0;
		foreach (mid_map[i]) mid_map[i] = '0;
		foreach (low_map[i]) low_map[i] = '0;
		foreach (leaf_map[i]) leaf_map[i] = '0;
		free_total = 0;
		errors = 0;
		hold_req = 1'b0;
		quiet = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (request_table[i])
			send_request(request_table[i].op, request_table[i].slot, request_table[i].first,
				request_table[i].last, request_table[i].known, request_table[i].want,
				pick_gap());

		// Let the block drain completely before the random part starts.
		req.valid <= 1'b0;
		wait (pending_results.size() == 0);
		@(posedge clk);

		for (int n = 0; n < 1750; n++) begin
			if (n % 250 == 0) quiet = (n % 500 == 250);
			if (n == 600) hold_req = 1'b1;
			op = 2'($urandom_range(0, 3));
			slot = 20'($urandom());
			first = 20'($urandom());
			last = 21'($urandom());
			r = $urandom_range(0, 99);
			if (r < 42) begin
				op = OP_ALLOC;
			end else if (r < 62) begin
				op = OP_FREE;
				if (owned_slots.size() > 0) begin
					pick = $urandom_range(0, owned_slots.size() - 1);
					slot = 20'(owned_slots[pick]);
					owned_slots.delete(pick);
				end
			end else if (r < 72) begin
				op = OP_FREE;
			end else if (r < 90) begin
				op = OP_RANGE;
				len = ($urandom_range(0, 49) == 0) ? $urandom_range(1, 3000)
					: $urandom_range(1, 64);
				last = 21'(first) + 21'(len);
			end else if (r < 94) begin
				op = OP_RANGE;
				last = 21'($urandom_range(0, first));
			end else if (r < 97) begin
				// Ranges whose end lies past the last slot are clipped.
				op = OP_RANGE;
				len = $urandom_range(1, 40);
				first = 20'(SlotTotal - len);
				last = 21'($urandom_range(SlotTotal, 21'h1FFFFF));
			end else begin
				op = OP_NONE;
			end
			send_request(op, slot, first, last, 1'b0, '0, (n >= 600 && n < 640) ? 0 : pick_gap());
		end
		req.valid <= 1'b0;

		wait (pending_results.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/hbsa_pkg.sv
hdl/hbsa_req_if.sv
hdl/hbsa_rsp_if.sv
hdl/hbsa_ram.sv
hdl/hierarchical_bitmap_slot_allocator.sv
sim/tb_top.sv
